// ===== hw/rtl/rans_encoder_bitwise_top_defines.svh =====
`ifndef RANS_ENCODER_BITWISE_TOP_DEFINES_SVH
`define RANS_ENCODER_BITWISE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RANS_EB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rans encoder check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RANS_EB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rans encoder check failed");

`endif

// ===== hw/rtl/rans_eb_pkg.sv =====
package rans_eb_pkg;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int FREQ_W     = 13;
    localparam int CUM_W      = 12;
    localparam int STATE_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Default table depth and coding precision.
    localparam int SYM_COUNT_DEF = 256;
    localparam int PREC_BITS     = 12;

    // Register reset values.
    localparam logic [FREQ_W-1:0]  TOTAL_FREQ_RST = FREQ_W'(1 << PREC_BITS);
    localparam logic [STATE_W-1:0] INIT_STATE_RST = STATE_W'(4096);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_BIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] freq_in;
        logic [CUM_W-1:0]  cum_in;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               bit_res;
        logic [STATE_W-1:0] coder_value;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [CUM_W-1:0]  cum;
    } table_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SHIFT
    } enc_state_t;

endpackage

// ===== hw/rtl/rans_encoder_bitwise_top.sv =====
// rANS encoder with one-bit renormalization.
// Input channel (s_valid/s_ready/s_data) takes three kinds of transaction:
// a table write stores a symbol's frequency and cumulative start, a restart
// loads the coder state from the initial_state register, and an encode
// emits one result per renormalization bit followed by a done result that
// carries the new state (or a single error result for a zero frequency).
// Results leave on m_valid/m_ready/m_data through a one-entry output register.
// Table writes and restarts leave s_ready high. An encode holds s_ready low
// while the table entry read at acceptance is registered (ST_LOOKUP) and
// while the shift loop (ST_SHIFT) issues one result per cycle, unless m_ready
// stalls it; the number of bits shifted out is 0 to 15.
// The first result of an encode is registered in ST_SHIFT, after ST_LOOKUP.
// A stall on m_ready freezes the shift loop; the pending result is held.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at once; the
// user must make them only while the block is idle; it is not enforced.
// Reset clears the sequencer and output valid, sets total_freq to 4096 and
// initial_state and the coder state to 4096. Table contents are undefined
// until written; no clearing pass runs.
module rans_encoder_bitwise_top #(
    parameter int SYM_COUNT = rans_eb_pkg::SYM_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rans_eb_pkg::in_item_t                 s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rans_eb_pkg::out_item_t                m_data,
    input  logic                                  cfg_we,
    input  logic [rans_eb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rans_eb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = $clog2(SYM_COUNT);

    logic [rans_eb_pkg::FREQ_W-1:0]  total_freq_reg;
    logic [rans_eb_pkg::STATE_W-1:0] initial_state_reg;
    logic                            tbl_we;
    logic                            tbl_re;
    logic [ADDR_W-1:0]               tbl_addr;
    rans_eb_pkg::table_entry_t       tbl_wdata;
    rans_eb_pkg::table_entry_t       tbl_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_freq_reg    <= rans_eb_pkg::TOTAL_FREQ_RST;
            initial_state_reg <= rans_eb_pkg::INIT_STATE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                rans_eb_pkg::CFG_TOTAL_FREQ: begin
                    total_freq_reg <= cfg_wdata[rans_eb_pkg::FREQ_W-1:0];
                end
                rans_eb_pkg::CFG_INIT_STATE: begin
                    initial_state_reg <= cfg_wdata[rans_eb_pkg::STATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer and coding datapath.
    rans_eb_ctrl #(
        .SYM_COUNT (SYM_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .total_freq    (total_freq_reg),
        .initial_state (initial_state_reg),
        .tbl_we        (tbl_we),
        .tbl_re        (tbl_re),
        .tbl_addr      (tbl_addr),
        .tbl_wdata     (tbl_wdata),
        .tbl_rdata     (tbl_rdata)
    );

    // Frequency and cumulative start table.
    rans_eb_table #(
        .SYM_COUNT (SYM_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .aclk      (aclk),
        .tbl_we    (tbl_we),
        .tbl_re    (tbl_re),
        .tbl_addr  (tbl_addr),
        .tbl_wdata (tbl_wdata),
        .tbl_rdata (tbl_rdata)
    );

endmodule

// ===== hw/rtl/rans_eb_table.sv =====
module rans_eb_table #(
    parameter int SYM_COUNT = rans_eb_pkg::SYM_COUNT_DEF,
    parameter int ADDR_W    = $clog2(SYM_COUNT)
) (
    input  logic                      aclk,
    input  logic                      tbl_we,
    input  logic                      tbl_re,
    input  logic [ADDR_W-1:0]         tbl_addr,
    input  rans_eb_pkg::table_entry_t tbl_wdata,
    output rans_eb_pkg::table_entry_t tbl_rdata
);

    rans_eb_pkg::table_entry_t mem [SYM_COUNT];
    rans_eb_pkg::table_entry_t rdata_reg;

    // Single-port symbol table with a registered read.
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            mem[tbl_addr] <= tbl_wdata;
        end
        if (tbl_re) begin
            rdata_reg <= mem[tbl_addr];
        end
    end

    assign tbl_rdata = rdata_reg;

endmodule

// ===== hw/rtl/rans_eb_ctrl.sv =====
module rans_eb_ctrl #(
    parameter int SYM_COUNT = rans_eb_pkg::SYM_COUNT_DEF,
    parameter int ADDR_W    = $clog2(SYM_COUNT)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rans_eb_pkg::in_item_t                 s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rans_eb_pkg::out_item_t                m_data,
    input  logic [rans_eb_pkg::FREQ_W-1:0]        total_freq,
    input  logic [rans_eb_pkg::STATE_W-1:0]       initial_state,
    output logic                                  tbl_we,
    output logic                                  tbl_re,
    output logic [ADDR_W-1:0]                     tbl_addr,
    output rans_eb_pkg::table_entry_t             tbl_wdata,
    input  rans_eb_pkg::table_entry_t             tbl_rdata
);

    localparam int STATE_W = rans_eb_pkg::STATE_W;
    localparam int FREQ_W  = rans_eb_pkg::FREQ_W;
    localparam int CUM_W   = rans_eb_pkg::CUM_W;

    rans_eb_pkg::enc_state_t state_reg, state_next;
    logic [STATE_W-1:0]      coder_state_reg, coder_state_next;
    logic [FREQ_W-1:0]       f_reg, f_next;
    logic [CUM_W-1:0]        c_reg, c_next;
    logic                    err_reg, err_next;
    logic                    sym_ok_reg, sym_ok_next;
    logic                    m_valid_reg, m_valid_next;
    rans_eb_pkg::out_item_t  m_data_reg, m_data_next;

    logic                    sym_ok;
    logic                    out_free;
    logic [STATE_W:0]        two_f;
    logic                    need_shift;
    logic                    s_ge_f;
    logic [STATE_W-1:0]      rem;
    logic [STATE_W-1:0]      scaled;
    logic [STATE_W-1:0]      new_state;

    assign sym_ok   = 32'(s_data.symbol) < SYM_COUNT;
    assign out_free = !m_valid_reg || m_ready;

    // Renormalization test and the single-step quotient: once the state is
    // below twice the frequency, the quotient is either zero or one.
    assign two_f      = (STATE_W + 1)'({f_reg, 1'b0});
    assign need_shift = {1'b0, coder_state_reg} >= two_f;
    assign s_ge_f     = coder_state_reg >= STATE_W'(f_reg);
    assign rem        = s_ge_f ? coder_state_reg - STATE_W'(f_reg) : coder_state_reg;
    assign scaled     = s_ge_f ? STATE_W'(total_freq) : '0;
    assign new_state  = scaled + STATE_W'(c_reg) + rem;

    // Table port: writes and lookups both use the incoming symbol.
    assign tbl_addr  = ADDR_W'(s_data.symbol);
    assign tbl_wdata = '{freq: s_data.freq_in, cum: s_data.cum_in};

    // Sequencer: next state, datapath updates and result register loads.
    always_comb begin
        state_next       = state_reg;
        coder_state_next = coder_state_reg;
        f_next           = f_reg;
        c_next           = c_reg;
        err_next         = err_reg;
        sym_ok_next      = sym_ok_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        s_ready          = 1'b0;
        tbl_we           = 1'b0;
        tbl_re           = 1'b0;

        case (state_reg)
            rans_eb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.op)
                        rans_eb_pkg::OP_WRITE: begin
                            tbl_we = sym_ok;
                        end
                        rans_eb_pkg::OP_ENCODE: begin
                            tbl_re      = 1'b1;
                            sym_ok_next = sym_ok;
                            state_next  = rans_eb_pkg::ST_LOOKUP;
                        end
                        rans_eb_pkg::OP_RESTART: begin
                            coder_state_next = initial_state;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rans_eb_pkg::ST_LOOKUP: begin
                f_next     = tbl_rdata.freq;
                c_next     = tbl_rdata.cum;
                err_next   = !sym_ok_reg || (tbl_rdata.freq == '0);
                state_next = rans_eb_pkg::ST_SHIFT;
            end
            rans_eb_pkg::ST_SHIFT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next = '{kind: rans_eb_pkg::KIND_ERR, bit_res: 1'b0,
                                        coder_value: coder_state_reg, last: 1'b1};
                        state_next  = rans_eb_pkg::ST_IDLE;
                    end else if (need_shift) begin
                        m_data_next = '{kind: rans_eb_pkg::KIND_BIT,
                                        bit_res: coder_state_reg[0],
                                        coder_value: '0, last: 1'b0};
                        coder_state_next = coder_state_reg >> 1;
                    end else begin
                        m_data_next = '{kind: rans_eb_pkg::KIND_DONE, bit_res: 1'b0,
                                        coder_value: new_state, last: 1'b1};
                        coder_state_next = new_state;
                        state_next       = rans_eb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rans_eb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and coder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rans_eb_pkg::ST_IDLE;
            coder_state_reg <= rans_eb_pkg::INIT_STATE_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            coder_state_reg <= coder_state_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        f_reg      <= f_next;
        c_reg      <= c_next;
        err_reg    <= err_next;
        sym_ok_reg <= sym_ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/rans_eb_checker.sv =====
`include "rans_encoder_bitwise_top_defines.svh"

module rans_eb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input rans_eb_pkg::in_item_t              s_data,
    input logic                               m_valid,
    input logic                               m_ready,
    input rans_eb_pkg::out_item_t             m_data
);

    logic enc_accept;
    logic bit_pending;

    assign enc_accept  = s_valid && s_ready && (s_data.op == rans_eb_pkg::OP_ENCODE);
    assign bit_pending = m_valid && (m_data.kind == rans_eb_pkg::KIND_BIT);

    // A stalled result holds its payload.
    `RANS_EB_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))

    // An accepted encode transaction keeps the input side closed next cycle.
    `RANS_EB_ASSERT_NEXT(a_encode_busy, aclk, aresetn, enc_accept, !s_ready)

    // While a bit result waits, the encode is unfinished and no input is taken.
    `RANS_EB_ASSERT_SAME(a_bit_busy, aclk, aresetn, bit_pending, !s_ready && !m_data.last)

    // Leaving reset, no result is shown.
    `RANS_EB_ASSERT_SAME(a_reset_quiet, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind rans_encoder_bitwise_top rans_eb_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

// ===== dv/tb_rans_encoder_bitwise_top.sv =====
import rans_eb_pkg::*;

// Tracks the encoder state, the symbol table and both registers. Each accepted
// input transaction is turned into the result transactions it must produce.
class coder_scoreboard;
    logic [FREQ_W-1:0]  freq_tab [SYM_COUNT_DEF];
    logic [CUM_W-1:0]   cum_tab [SYM_COUNT_DEF];
    logic [STATE_W-1:0] coder_state;
    logic [FREQ_W-1:0]  reg_total;
    logic [STATE_W-1:0] reg_init;
    out_item_t          pending_outputs [$];
    int                 errors;
    int                 inputs_seen;
    int                 encodes_seen;
    int                 results_seen;
    int                 zero_freq_seen;

    function new();
        reg_total   = TOTAL_FREQ_RST;
        reg_init    = INIT_STATE_RST;
        coder_state = INIT_STATE_RST;
        foreach (freq_tab[i]) begin
            freq_tab[i] = '0;
            cum_tab[i]  = '0;
        end
    endfunction

    task report(input string msg);
        if (errors < 40) begin
            $display("mismatch: %s", msg);
        end
        errors++;
    endtask

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        if (idx == CFG_TOTAL_FREQ) begin
            reg_total = data[FREQ_W-1:0];
        end else begin
            reg_init = data;
        end
    endfunction

    // Renormalize one bit at a time, then fold the symbol into the state.
    function void encode_symbol(input logic [SYM_W-1:0] sym);
        int unsigned f;
        int unsigned c;
        int unsigned s;
        int unsigned q;
        int unsigned r;
        out_item_t   res;
        f   = 32'(freq_tab[sym]);
        c   = 32'(cum_tab[sym]);
        res = '0;
        if (f == 0) begin
            res.kind        = KIND_ERR;
            res.coder_value = coder_state;
            res.last        = 1'b1;
            pending_outputs.insert(pending_outputs.size(), res);
            return;
        end
        s = 32'(coder_state);
        while (s >= 2 * f) begin
            res.kind    = KIND_BIT;
            res.bit_res = s[0];
            pending_outputs.insert(pending_outputs.size(), res);
            s = s >> 1;
        end
        q = s / f;
        r = s % f;
        s = q * 32'(reg_total) + c + r;
        coder_state     = s[STATE_W-1:0];
        res             = '0;
        res.kind        = KIND_DONE;
        res.coder_value = coder_state;
        res.last        = 1'b1;
        pending_outputs.insert(pending_outputs.size(), res);
    endfunction

    function void note_transaction(input in_item_t it);
        inputs_seen++;
        if (it.op == OP_WRITE) begin
            freq_tab[it.symbol] = it.freq_in;
            cum_tab[it.symbol]  = it.cum_in;
        end else if (it.op == OP_RESTART) begin
            coder_state = reg_init;
        end else if (it.op == OP_ENCODE) begin
            encodes_seen++;
            encode_symbol(it.symbol);
        end
    endfunction

    task check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (pending_outputs.size() == 0) begin
            report($sformatf("unexpected result kind=%0d value=%0d", got.kind,
                             got.coder_value));
            return;
        end
        want = pending_outputs.pop_front();
        if (want.kind == KIND_ERR) begin
            zero_freq_seen++;
        end
        if (got.kind !== want.kind) begin
            report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
        end
        if (got.bit_res !== want.bit_res) begin
            report($sformatf("bit_res %0b, wanted %0b", got.bit_res, want.bit_res));
        end
        if (got.coder_value !== want.coder_value) begin
            report($sformatf("coder_value %0d, wanted %0d", got.coder_value,
                             want.coder_value));
        end
        if (got.last !== want.last) begin
            report($sformatf("last %0b, wanted %0b", got.last, want.last));
        end
    endtask
endclass

module tb_rans_encoder_bitwise_top;

    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    coder_scoreboard board;
    int              cycle_count = 0;
    int              src_idle_pct = 11;
    int              rcv_idle_pct = 80;
    int              settings_used = 1;
    logic [SYM_W-1:0] written_syms [$];
    bit              entry_written [SYM_COUNT_DEF];

    rans_encoder_bitwise_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_rans_encoder_bitwise_top: errors");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        board.note_transaction(it);
        if (it.op == OP_WRITE && !entry_written[it.symbol]) begin
            entry_written[it.symbol] = 1'b1;
            written_syms.insert(written_syms.size(), it.symbol);
        end
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input int f, input int c);
        in_item_t it;
        it.op      = op;
        it.symbol  = sym;
        it.freq_in = f[FREQ_W-1:0];
        it.cum_in  = c[CUM_W-1:0];
        send_item(it);
    endtask

    // Mostly encodes of known symbols, with table updates, restarts and noise.
    task automatic send_random(output bit counted);
        in_item_t it;
        int       roll;
        int       fsel;
        roll       = $urandom_range(0, 99);
        fsel       = $urandom_range(0, 99);
        it.symbol  = SYM_W'($urandom_range(0, 255));
        it.freq_in = FREQ_W'($urandom_range(0, 8191));
        it.cum_in  = CUM_W'($urandom_range(0, 4095));
        counted    = 1'b1;
        if (roll < 18 || written_syms.size() == 0) begin
            it.op = OP_WRITE;
            if (fsel < 6) begin
                it.freq_in = '0;
            end else if (fsel < 14) begin
                it.freq_in = FREQ_W'(4096);
            end else if (fsel < 55) begin
                it.freq_in = FREQ_W'($urandom_range(1, 16));
            end else begin
                it.freq_in = FREQ_W'($urandom_range(1, 4096));
            end
        end else if (roll < 24) begin
            it.op = OP_RESTART;
        end else if (roll < 27) begin
            it.op   = OP_UNUSED;
            counted = 1'b0;
        end else begin
            it.op     = OP_ENCODE;
            it.symbol = written_syms[$urandom_range(0, written_syms.size() - 1)];
        end
        send_item(it);
    endtask

    task automatic run_random(input int n);
        int count;
        bit counted;
        count = 0;
        while (count < n) begin
            send_random(counted);
            if (counted) begin
                count++;
            end
        end
    endtask

    // Let every expected result arrive, then give the block time to go idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(input int total, input int init);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TOTAL_FREQ;
        cfg_wdata <= total[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_addr  <= CFG_INIT_STATE;
        cfg_wdata <= init[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.write_reg(CFG_TOTAL_FREQ, total[15:0]);
        board.write_reg(CFG_INIT_STATE, init[15:0]);
        settings_used++;
    endtask

    initial begin
        int total;
        int init;
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with reset register values: table extremes, zero
        // frequency, long renormalization, restart and the unused operation.
        send_op(OP_WRITE, 8'd0, 1, 0);
        send_op(OP_WRITE, 8'd255, 4096, 4095);
        send_op(OP_WRITE, 8'd1, 0, 4095);
        send_op(OP_WRITE, 8'd170, 2730, 1365);
        send_op(OP_WRITE, 8'd85, 1365, 2730);
        send_op(OP_ENCODE, 8'd0, 0, 0);
        send_op(OP_ENCODE, 8'd255, 0, 0);
        send_op(OP_ENCODE, 8'd1, 8191, 4095);
        send_op(OP_ENCODE, 8'd170, 0, 0);
        send_op(OP_RESTART, 8'd255, 8191, 4095);
        send_op(OP_ENCODE, 8'd85, 0, 0);
        send_op(OP_UNUSED, 8'd170, 5461, 2730);
        send_op(OP_ENCODE, 8'd255, 0, 0);
        send_op(OP_WRITE, 8'd0, 4096, 0);
        send_op(OP_ENCODE, 8'd0, 0, 0);
        send_op(OP_RESTART, 8'd0, 0, 0);
        send_op(OP_ENCODE, 8'd1, 0, 0);
        send_op(OP_WRITE, 8'd2, 2, 4095);
        send_op(OP_ENCODE, 8'd2, 0, 0);
        send_op(OP_ENCODE, 8'd2, 0, 0);
        send_op(OP_ENCODE, 8'd255, 0, 0);
        run_random(40);

        // Each later phase moves both registers; the first encode still runs
        // on the old state, since only a restart loads initial_state.
        for (int ph = 1; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                1: begin
                    total = 1;
                    init  = 65535;
                end
                2: begin
                    total = 4096;
                    init  = 0;
                end
                4: begin
                    total = 2;
                    init  = 1;
                end
                default: begin
                    total = $urandom_range(1, 4096);
                    init  = $urandom_range(0, 65535);
                end
            endcase
            if (ph >= 4) begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (ph >= 2) begin
                src_idle_pct = 80;
                rcv_idle_pct = 11;
            end
            set_config(total, init);
            send_op(OP_ENCODE, written_syms[$urandom_range(0, written_syms.size() - 1)],
                    0, 0);
            send_op(OP_RESTART, 8'd0, 0, 0);
            run_random(60);
        end

        wait_drained();
        if (board.pending_outputs.size() != 0) begin
            board.report($sformatf("%0d results never arrived",
                                   board.pending_outputs.size()));
        end
        $display("covered %0d input transactions (%0d encodes), %0d results checked",
                 board.inputs_seen, board.encodes_seen, board.results_seen);
        $display("%0d zero-frequency errors seen across %0d register settings",
                 board.zero_freq_seen, settings_used);
        if (board.errors == 0) begin
            $display("tb_rans_encoder_bitwise_top: clean");
        end else begin
            $display("tb_rans_encoder_bitwise_top: errors");
        end
        $finish;
    end

endmodule
